// ===== hdl/oamdma_pkg.sv =====
// shared types and constants for the sprite-table dma controller and bus arbiter
package oamdma_pkg;

    // bytes moved by one dma transfer (at most 256)
    localparam int DMA_LENGTH = 160;

    localparam int IDX_W = 9;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_INTERNAL = 3'd2,
        CMD_START    = 3'd3,
        CMD_REG_READ = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NORMAL     = 3'd0,
        ACT_READ_FF    = 3'd1,
        ACT_READ_DMA   = 3'd2,
        ACT_WRITE_DROP = 3'd3,
        ACT_NONE       = 3'd4
    } action_t;

    localparam logic [7:0]  HIGH_PAGE_MASK = 8'hE0;
    localparam logic [7:0]  HIGH_PAGE_CLR  = 8'hDF;
    localparam logic [7:0]  OAM_PAGE       = 8'hFE;
    localparam logic [1:0]  SHARED_BUS     = 2'd2;
    localparam logic signed [IDX_W-1:0] IDX_START   = -9'sd2;
    localparam logic signed [IDX_W-1:0] IDX_RESTART = -9'sd1;

endpackage

// ===== hdl/oam_dma_bus_arbiter_unit.sv =====
// sprite-table dma controller and cpu bus conflict arbiter
// stages: the input register, then the result register
// throughput: one item per cycle; a stall on the result side holds both stages
// the dma counter and the page and bus registers update as an item passes the input register
// reset: asynchronous, clears the dma state (idle, page 0, bus 0, index 0) and the valid flags of both stages
module oam_dma_bus_arbiter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [15:0] addr,
    input  logic [1:0]  page_bus,
    input  logic [7:0]  page_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dma_valid,
    output logic [15:0] dma_src_addr,
    output logic [7:0]  oam_index,
    output logic [2:0]  cpu_action,
    output logic [7:0]  reg_value,
    output logic        dma_busy
);
    import oamdma_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [1:0]  bus_reg;
    logic [7:0]  value_reg;

    // dma state
    logic                    active_reg, active_next;
    logic [7:0]              page_reg, page_next;
    logic [1:0]              bus_id_reg, bus_id_next;
    logic signed [IDX_W-1:0] index_reg, index_next;

    // result stage
    logic        out_valid_reg;
    logic        dma_valid_reg, dma_valid_next;
    logic [15:0] src_reg, src_next;
    logic [7:0]  oidx_reg, oidx_next;
    action_t     action_reg, action_next;
    logic [7:0]  regv_reg, regv_next;
    logic        busy_reg;

    logic                    out_ready;
    logic                    in_ready;
    logic                    advance;
    logic signed [IDX_W-1:0] idx_inc;
    logic                    tick;
    logic                    moved;
    logic [7:0]              mapped_page;
    cmd_t                    cmd_c;

    assign out_ready = !out_valid_reg || !out_stall;
    assign in_ready  = !in_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = !in_ready;

    always_comb
    begin
        cmd_c          = cmd_t'(cmd_reg);
        idx_inc        = index_reg + 9'sd1;
        tick           = 1'b0;
        active_next    = active_reg;
        page_next      = page_reg;
        bus_id_next    = bus_id_reg;
        index_next     = index_reg;
        action_next    = ACT_NONE;
        regv_next      = '0;
        mapped_page    = value_reg;
        if ((value_reg & HIGH_PAGE_MASK) == HIGH_PAGE_MASK)
        begin
            mapped_page = value_reg & HIGH_PAGE_CLR;
        end

        case (cmd_c)
            CMD_READ, CMD_WRITE, CMD_INTERNAL:
            begin
                tick = active_reg;
            end
            default:
            begin
                tick = 1'b0;
            end
        endcase

        moved = tick && !idx_inc[IDX_W-1];
        if (tick)
        begin
            index_next = idx_inc;
            if (moved && idx_inc >= $signed(IDX_W'(DMA_LENGTH - 1)))
            begin
                active_next = 1'b0;
            end
        end

        case (cmd_c)
            CMD_READ:
            begin
                action_next = ACT_NORMAL;
                if (moved)
                begin
                    if (addr_reg[15:8] == OAM_PAGE)
                    begin
                        action_next = ACT_READ_FF;
                    end
                    else if (bus_reg == bus_id_reg)
                    begin
                        action_next = ACT_READ_DMA;
                    end
                end
            end
            CMD_WRITE:
            begin
                action_next = ACT_NORMAL;
                if (moved && (bus_reg == SHARED_BUS || bus_reg == bus_id_reg))
                begin
                    action_next = ACT_WRITE_DROP;
                end
            end
            CMD_INTERNAL:
            begin
                action_next = ACT_NONE;
            end
            CMD_START:
            begin
                page_next   = mapped_page;
                bus_id_next = bus_reg;
                active_next = 1'b1;
                // restart while busy waits one event less
                index_next  = active_reg ? IDX_RESTART : IDX_START;
                action_next = ACT_NORMAL;
            end
            CMD_REG_READ:
            begin
                regv_next   = page_reg;
                action_next = ACT_NORMAL;
            end
            default:
            begin
                action_next = ACT_NONE;
            end
        endcase

        dma_valid_next = moved;
        src_next       = moved ? {page_reg, idx_inc[7:0]} : 16'h0000;
        oidx_next      = moved ? idx_inc[7:0] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            page_reg      <= '0;
            bus_id_reg    <= '0;
            index_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                active_reg <= active_next;
                page_reg   <= page_next;
                bus_id_reg <= bus_id_next;
                index_reg  <= index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg   <= cmd;
            addr_reg  <= addr;
            bus_reg   <= page_bus;
            value_reg <= page_value;
        end
        if (advance)
        begin
            dma_valid_reg <= dma_valid_next;
            src_reg       <= src_next;
            oidx_reg      <= oidx_next;
            action_reg    <= action_next;
            regv_reg      <= regv_next;
            busy_reg      <= active_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dma_valid    = dma_valid_reg;
    assign dma_src_addr = src_reg;
    assign oam_index    = oidx_reg;
    assign cpu_action   = action_reg;
    assign reg_value    = regv_reg;
    assign dma_busy     = busy_reg;

endmodule

// ===== hdl/oam_dma_bus_arbiter_checker.sv =====
// port-level checks for the dma arbiter and their binding to the arbiter unit
module oam_dma_bus_arbiter_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        dma_valid,
    input logic [15:0] dma_src_addr,
    input logic [7:0]  oam_index,
    input logic [2:0]  cpu_action
);
    import oamdma_pkg::*;

    // sprite index is the low byte of the source address
    a_index_matches_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dma_valid |-> oam_index == dma_src_addr[7:0])
        else $error("oam index does not match source address");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dma_valid |-> dma_src_addr == 16'h0000 && oam_index == 8'h00)
        else $error("address fields set without a moved byte");

    // conflict actions only arise while a byte moves
    a_conflict_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cpu_action == ACT_READ_FF || cpu_action == ACT_READ_DMA
            || cpu_action == ACT_WRITE_DROP) |-> dma_valid)
        else $error("bus conflict reported without a dma byte");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dma_valid |-> 32'(oam_index) < DMA_LENGTH)
        else $error("sprite index beyond transfer length");

    a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dma_src_addr)
            && $stable(cpu_action))
        else $error("stalled result changed");

endmodule

bind oam_dma_bus_arbiter_unit oam_dma_bus_arbiter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dma_valid    (dma_valid),
    .dma_src_addr (dma_src_addr),
    .oam_index    (oam_index),
    .cpu_action   (cpu_action)
);

// ===== dv/tb.sv =====
// testbench for the sprite-table dma controller and bus arbiter: random bus events checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oamdma_pkg::*;

    localparam int ITEM_COUNT = 550;
    localparam int QUIET_TAIL = 470;
    localparam int IDLE_LIMIT = 500;

    typedef struct {
        logic        moved;
        logic [15:0] src_addr;
        logic [7:0]  oam_idx;
        logic [2:0]  action;
        logic [7:0]  page_reg;
        logic        busy;
    } bus_result_t;

    // tracks the dma state and holds the predicted result of every accepted item
    class dma_event_tracker;
        bit          active;
        logic [7:0]  page;
        logic [1:0]  bus_id;
        int          index;
        bus_result_t pending[$];
        int          errors;

        function new();
            active = 1'b0;
            page   = 8'h00;
            bus_id = 2'd0;
            index  = 0;
            errors = 0;
        endfunction

        // one bus step of the transfer; returns 1 when a byte moves
        function bit advance_transfer(output logic [15:0] src, output logic [7:0] oidx);
            src  = 16'h0000;
            oidx = 8'h00;
            if (!active)
                return 1'b0;
            index = index + 1;
            if (index < 0)
                return 1'b0;
            src  = {page, 8'(index)};
            oidx = 8'(index);
            if (index >= DMA_LENGTH - 1)
                active = 1'b0;
            return 1'b1;
        endfunction

        function void note_item(logic [2:0] c, logic [15:0] a, logic [1:0] pb, logic [7:0] pv);
            bus_result_t r;
            logic [7:0]  mapped;
            r.moved    = 1'b0;
            r.src_addr = 16'h0000;
            r.oam_idx  = 8'h00;
            r.action   = ACT_NONE;
            r.page_reg = 8'h00;
            case (c)
                CMD_READ:
                begin
                    r.moved  = advance_transfer(r.src_addr, r.oam_idx);
                    r.action = ACT_NORMAL;
                    if (r.moved)
                    begin
                        if (a[15:8] == OAM_PAGE)
                            r.action = ACT_READ_FF;
                        else if (pb == bus_id)
                            r.action = ACT_READ_DMA;
                    end
                end
                CMD_WRITE:
                begin
                    r.moved  = advance_transfer(r.src_addr, r.oam_idx);
                    r.action = ACT_NORMAL;
                    if (r.moved && (pb == SHARED_BUS || pb == bus_id))
                        r.action = ACT_WRITE_DROP;
                end
                CMD_INTERNAL:
                begin
                    r.moved  = advance_transfer(r.src_addr, r.oam_idx);
                    r.action = ACT_NONE;
                end
                CMD_START:
                begin
                    // high pages mirror down by clearing bit 5
                    mapped = pv;
                    if ((pv & HIGH_PAGE_MASK) == HIGH_PAGE_MASK)
                        mapped = pv & HIGH_PAGE_CLR;
                    page   = mapped;
                    bus_id = pb;
                    if (!active)
                    begin
                        active = 1'b1;
                        index  = -2;
                    end
                    else
                        index = -1;
                    r.action = ACT_NORMAL;
                end
                CMD_REG_READ:
                begin
                    r.page_reg = page;
                    r.action   = ACT_NORMAL;
                end
                default:
                    r.action = ACT_NONE;
            endcase
            r.busy = active;
            pending.push_back(r);
        endfunction

        function void check_result(bus_result_t got);
            bus_result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no item waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.moved !== want.moved)
            begin
                $error("dma_valid: expected %0d, got %0d", want.moved, got.moved);
                errors++;
            end
            if (got.src_addr !== want.src_addr)
            begin
                $error("dma_src_addr: expected %h, got %h", want.src_addr, got.src_addr);
                errors++;
            end
            if (got.oam_idx !== want.oam_idx)
            begin
                $error("oam_index: expected %0d, got %0d", want.oam_idx, got.oam_idx);
                errors++;
            end
            if (got.action !== want.action)
            begin
                $error("cpu_action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.page_reg !== want.page_reg)
            begin
                $error("reg_value: expected %h, got %h", want.page_reg, got.page_reg);
                errors++;
            end
            if (got.busy !== want.busy)
            begin
                $error("dma_busy: expected %0d, got %0d", want.busy, got.busy);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = 3'd0;
    logic [15:0] addr = 16'h0000;
    logic [1:0]  page_bus = 2'd0;
    logic [7:0]  page_value = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        dma_valid;
    logic [15:0] dma_src_addr;
    logic [7:0]  oam_index;
    logic [2:0]  cpu_action;
    logic [7:0]  reg_value;
    logic        dma_busy;

    dma_event_tracker tracker;
    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;
    int items_sent = 0;
    int idle_cycles = 0;

    oam_dma_bus_arbiter_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .addr         (addr),
        .page_bus     (page_bus),
        .page_value   (page_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dma_valid    (dma_valid),
        .dma_src_addr (dma_src_addr),
        .oam_index    (oam_index),
        .cpu_action   (cpu_action),
        .reg_value    (reg_value),
        .dma_busy     (dma_busy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // accepted items feed the predictor, accepted results are checked
    always @(posedge clk)
    begin
        bus_result_t got;
        if (rst_n && in_valid && !in_stall)
            tracker.note_item(cmd, addr, page_bus, page_value);
        if (rst_n && out_valid && !out_stall)
        begin
            got.moved    = dma_valid;
            got.src_addr = dma_src_addr;
            got.oam_idx  = oam_index;
            got.action   = cpu_action;
            got.page_reg = reg_value;
            got.busy     = dma_busy;
            tracker.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side stalls in short bursts
    always
    begin
        @(negedge clk);
        if (receiver_stalls && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        out_stall <= 1'b0;
    end

    task automatic send_item(input logic [2:0] c, input logic [15:0] a,
                             input logic [1:0] pb, input logic [7:0] pv);
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        addr       <= a;
        page_bus   <= pb;
        page_value <= pv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c <= CMD_REG_READ)
            items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_bus_event();
        logic [15:0] a;
        logic [2:0]  c;
        if ($urandom_range(0, 3) == 0)
            a = {OAM_PAGE, 8'($urandom)};
        else
            a = 16'($urandom);
        case ($urandom_range(0, 2))
            0: c = CMD_READ;
            1: c = CMD_WRITE;
            default: c = CMD_INTERNAL;
        endcase
        send_item(c, a, 2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic send_start();
        logic [7:0] pv;
        if ($urandom_range(0, 2) == 0)
            pv = 8'($urandom_range(8'hE0, 8'hFF));
        else
            pv = 8'($urandom);
        send_item(CMD_START, 16'($urandom), 2'($urandom_range(0, 3)), pv);
    endtask

    // a start followed by a run of bus events, with the odd register read,
    // restart or unused command mixed in
    task automatic run_transfer();
        int n;
        int pick;
        send_start();
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(160, 175) : $urandom_range(1, 60);
        repeat (n)
        begin
            if (items_sent >= ITEM_COUNT)
                break;
            pick = $urandom_range(0, 29);
            if (pick == 0)
                send_item(CMD_REG_READ, 16'($urandom), 2'($urandom), 8'($urandom));
            else if (pick == 1)
                send_start();
            else if (pick == 2)
                send_item(3'($urandom_range(5, 7)), 16'($urandom), 2'($urandom), 8'($urandom));
            else
                send_bus_event();
        end
    endtask

    initial
    begin
        bit drained_once;
        drained_once = 1'b0;
        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle controller
        send_item(CMD_REG_READ, 16'h0000, 2'd0, 8'h00);
        send_item(CMD_READ, 16'h0000, 2'd0, 8'h00);
        send_item(CMD_WRITE, 16'hFFFF, 2'd3, 8'hFF);
        send_item(CMD_INTERNAL, 16'hFE00, 2'd1, 8'h00);
        send_item(3'd5, 16'h0000, 2'd0, 8'h00);
        send_item(3'd7, 16'hFFFF, 2'd3, 8'hFF);
        // high page mirrored down, then the wait and every conflict kind
        send_item(CMD_START, 16'h0000, 2'd3, 8'hFF);
        send_item(CMD_REG_READ, 16'h0000, 2'd0, 8'h00);
        send_item(CMD_READ, 16'hFE00, 2'd3, 8'h00);
        send_item(CMD_READ, 16'hFEFF, 2'd0, 8'h00);
        send_item(CMD_READ, 16'h1234, 2'd3, 8'h00);
        send_item(CMD_READ, 16'h1234, 2'd1, 8'h00);
        send_item(CMD_WRITE, 16'h8000, 2'd2, 8'h00);
        send_item(CMD_WRITE, 16'h8000, 2'd3, 8'h00);
        send_item(CMD_WRITE, 16'h8000, 2'd0, 8'h00);
        send_item(CMD_INTERNAL, 16'h0000, 2'd0, 8'h00);
        send_item(3'd6, 16'h0000, 2'd0, 8'h00);
        // restarts while busy
        send_item(CMD_START, 16'h0000, 2'd0, 8'hE0);
        send_item(CMD_READ, 16'hFE10, 2'd0, 8'h00);
        send_item(CMD_REG_READ, 16'h0000, 2'd0, 8'h00);
        send_item(CMD_START, 16'h0000, 2'd1, 8'hDF);
        send_item(CMD_WRITE, 16'h8000, 2'd1, 8'h00);
        send_item(CMD_START, 16'h0000, 2'd2, 8'h00);
        send_item(CMD_READ, 16'h0000, 2'd2, 8'h00);
        wait_for_results();

        while (items_sent < ITEM_COUNT)
        begin
            if (items_sent >= QUIET_TAIL)
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            if (!drained_once && items_sent >= ITEM_COUNT / 2)
            begin
                wait_for_results();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 8)) send_bus_event();
            else
                run_transfer();
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
